>>> design/prht_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prht_pkg
// Shared constants, types and modular helpers for the palindrome hash tree.
// ----------------------------------------------------------------------------
package prht_pkg;

   localparam int CAP_BITS  = 10;
   localparam int CAPACITY  = 1 << CAP_BITS;
   localparam int NODE_BITS = CAP_BITS + 1;   // tree node index, 2*CAPACITY nodes
   localparam int IDX_BITS  = NODE_BITS + 1;  // range walk bounds reach 2*CAPACITY
   localparam int LEN_W     = 11;
   localparam int HASH_W    = 30;
   localparam int CHAR_W    = 8;
   localparam int STEP_W    = 5;

   localparam logic [HASH_W-1:0] HASH_PRIME = 30'd1000000007;
   localparam logic [CHAR_W-1:0] HASH_BASE  = 8'd199;

   localparam logic [STEP_W-1:0] TOP_CHAR = 5'd7;
   localparam logic [STEP_W-1:0] TOP_HASH = 5'd29;

   // request word actions
   localparam logic ACT_SET   = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   // request to the modular multiplier; top is the index of the highest
   // multiplier bit to scan
   typedef struct packed {
      logic              start;
      logic [HASH_W-1:0] mcand;
      logic [HASH_W-1:0] mplier;
      logic [STEP_W-1:0] top;
   } mm_req_type;

   // (a + b) mod prime, both operands already reduced
   function automatic logic [HASH_W-1:0] mod_add(input logic [HASH_W-1:0] a,
                                                 input logic [HASH_W-1:0] b);
      logic [HASH_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, HASH_PRIME}) begin
         s = s - {1'b0, HASH_PRIME};
      end
      return s[HASH_W-1:0];
   endfunction

endpackage
`default_nettype wire

>>> design/prht_modmul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prht_modmul
// Bit-serial modular multiplier, one multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module prht_modmul (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire prht_pkg::mm_req_type      req,
   output logic                           done,
   output logic [prht_pkg::HASH_W-1:0]    product
);
   import prht_pkg::*;

   logic              run_ff;
   logic              done_ff;
   logic [STEP_W-1:0] idx_ff;
   logic [HASH_W-1:0] acc_ff;
   logic [HASH_W-1:0] mcand_ff;
   logic [HASH_W-1:0] mplier_ff;
   logic [HASH_W-1:0] acc_in;
   logic [HASH_W:0]   dbl;
   logic [HASH_W-1:0] dbl_red;

   // acc = 2*acc (+ mcand) mod prime
   always_comb begin
      dbl = {acc_ff, 1'b0};
      if (dbl >= {1'b0, HASH_PRIME}) begin
         dbl = dbl - {1'b0, HASH_PRIME};
      end
      dbl_red = dbl[HASH_W-1:0];
      acc_in  = mplier_ff[idx_ff] ? mod_add(dbl_red, mcand_ff) : dbl_red;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            run_ff    <= 1'b1;
            acc_ff    <= '0;
            idx_ff    <= req.top;
            mcand_ff  <= req.mcand;
            mplier_ff <= req.mplier;
         end else if (run_ff) begin
            acc_ff <= acc_in;
            if (idx_ff == '0) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               idx_ff <= idx_ff - 1'b1;
            end
         end
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule
`default_nettype wire

>>> design/palindrome_range_hash_tree_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// palindrome_range_hash_tree_unit
// Palindrome range checker over two polynomial hash sum trees (mod 1e9+7).
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_* and pulse start while busy is low; the word
//   is taken at that edge. Action 0 writes one character, action 1 queries
//   the inclusive range [req_position, req_range_end].
//   Result channel: a query returns one word on rsp_* marked by rsp_valid for
//   exactly one cycle. The receiver cannot stall; a set returns nothing.
//   CSR channel: csr_wdata is the string length; csr_ready is always high.
//   Sequence: a set runs two 8-step modular multiplies, each after a table
//   read, then a read state and a write state per tree level. A query
//   walks the tree with a left and a right state per level plus a summing
//   state per node summed, then a 30-step alignment multiply after a table
//   read, skipped for a centered range; a bad range answers the next cycle.
//   Both trees and the power table sit in single read-port synchronous RAMs;
//   one read per cycle per RAM sets the walk speed, the serial multiplier
//   sets the rest. One word is in flight at a time.
//   Reset: busy stays high while all 2048 tree nodes are cleared, then while
//   the table of powers of 199 is filled by serial multiplies.
// ----------------------------------------------------------------------------
module palindrome_range_hash_tree_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_action,
   input  wire logic [prht_pkg::CAP_BITS-1:0] req_position,
   input  wire logic [prht_pkg::CAP_BITS-1:0] req_range_end,
   input  wire logic [prht_pkg::CHAR_W-1:0]   req_char_value,
   output logic                               rsp_valid,
   output logic                               rsp_is_palindrome,
   output logic [prht_pkg::HASH_W-1:0]        rsp_forward_hash,
   output logic [prht_pkg::HASH_W-1:0]        rsp_reverse_hash,
   output logic                               rsp_range_error,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [prht_pkg::LEN_W-1:0]    csr_wdata
);
   import prht_pkg::*;

   typedef enum logic [4:0] {
      S_CLR, S_PW_MUL, S_PW_WAIT, S_IDLE,
      S_SET_P1, S_SET_M1, S_SET_W1, S_SET_P2, S_SET_M2, S_SET_W2,
      S_UP_RD, S_UP_WR,
      S_Q_L, S_Q_LD, S_Q_R, S_Q_RD,
      S_AL_RD, S_AL_M, S_AL_W, S_OUT
   } state_type;

   state_type state_ff;

   // storage
   logic [HASH_W-1:0] fwd_mem [2*CAPACITY];
   logic [HASH_W-1:0] rev_mem [2*CAPACITY];
   logic [HASH_W-1:0] pow_mem [CAPACITY];
   logic [HASH_W-1:0] fwd_rd_ff, rev_rd_ff, pow_rd_ff;

   // control / payload registers
   logic [LEN_W-1:0]     len_ff;
   logic [NODE_BITS-1:0] clr_ff;
   logic [CAP_BITS-1:0]  k_ff;
   logic [HASH_W-1:0]    pw_ff;
   logic [CAP_BITS-1:0]  pos_ff, end_ff;
   logic [CHAR_W-1:0]    ch_ff;
   logic [HASH_W-1:0]    fv_ff, rv_ff;     // set leaf values, query sums
   logic [NODE_BITS-1:0] node_ff;
   logic [IDX_BITS-1:0]  l_ff, r_ff;
   logic                 al_fwd_ff;        // align scales forward sum
   logic                 rsp_valid_ff, rsp_pal_ff, rsp_err_ff;
   logic [HASH_W-1:0]    rsp_fwd_ff, rsp_rev_ff;

   // memory port controls
   logic                 tree_we;
   logic [NODE_BITS-1:0] tree_wa, tree_ra;
   logic [HASH_W-1:0]    fwd_wd, rev_wd;
   logic                 pow_we;
   logic [CAP_BITS-1:0]  pow_wa, pow_ra;
   logic [HASH_W-1:0]    pow_wd;

   mm_req_type        mm_req;
   logic              mm_done;
   logic [HASH_W-1:0] mm_prod;

   logic [LEN_W-1:0]     len_m1;
   logic [CAP_BITS-1:0]  mirror, rev_idx;
   logic [NODE_BITS-1:0] parent;
   logic [HASH_W-1:0]    up_fwd, up_rev;

   prht_modmul u_mul (
      .clock   (clock),
      .reset   (reset),
      .req     (mm_req),
      .done    (mm_done),
      .product (mm_prod)
   );

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   assign len_m1  = len_ff - 1'b1;
   assign mirror  = CAP_BITS'(len_m1 - LEN_W'(end_ff));
   assign rev_idx = CAP_BITS'(len_m1 - LEN_W'(pos_ff));
   assign parent  = node_ff >> 1;
   assign up_fwd  = mod_add(fv_ff, fwd_rd_ff);
   assign up_rev  = mod_add(rv_ff, rev_rd_ff);

   // ---- memory address / data steering ----
   always_comb begin
      tree_we = 1'b0;
      tree_wa = node_ff;
      tree_ra = node_ff ^ NODE_BITS'(1);
      fwd_wd  = '0;
      rev_wd  = '0;
      pow_we  = 1'b0;
      pow_wa  = k_ff;
      pow_wd  = mm_prod;
      pow_ra  = pos_ff;
      mm_req  = '0;
      case (state_ff)
         S_CLR: begin
            tree_we = 1'b1;
            tree_wa = clr_ff;
            if (clr_ff == '0) begin
               // table entry 0 is 199^0
               pow_we = 1'b1;
               pow_wa = '0;
               pow_wd = HASH_W'(1);
            end
         end
         S_PW_MUL: begin
            mm_req.start  = 1'b1;
            mm_req.mcand  = pw_ff;
            mm_req.mplier = HASH_W'(HASH_BASE);
            mm_req.top    = TOP_CHAR;
         end
         S_PW_WAIT: pow_we = mm_done;
         S_SET_P1:  pow_ra = pos_ff;
         S_SET_M1, S_SET_M2: begin
            mm_req.start  = 1'b1;
            mm_req.mcand  = pow_rd_ff;
            mm_req.mplier = HASH_W'(ch_ff);
            mm_req.top    = TOP_CHAR;
         end
         S_SET_P2:  pow_ra = rev_idx;
         S_SET_W2: begin
            // leaf write once the reverse weight is ready
            tree_we = mm_done;
            tree_wa = NODE_BITS'(CAPACITY) + NODE_BITS'(pos_ff);
            fwd_wd  = fv_ff;
            rev_wd  = mm_prod;
         end
         S_UP_RD:   tree_ra = node_ff ^ NODE_BITS'(1);
         S_UP_WR: begin
            tree_we = 1'b1;
            tree_wa = parent;
            fwd_wd  = up_fwd;
            rev_wd  = up_rev;
         end
         S_Q_L:     tree_ra = l_ff[NODE_BITS-1:0];
         S_Q_R:     tree_ra = NODE_BITS'(r_ff - 1'b1);
         S_AL_RD:   pow_ra = (pos_ff < mirror) ? (mirror - pos_ff) : (pos_ff - mirror);
         S_AL_M: begin
            mm_req.start  = 1'b1;
            mm_req.mcand  = pow_rd_ff;
            mm_req.mplier = al_fwd_ff ? fv_ff : rv_ff;
            mm_req.top    = TOP_HASH;
         end
         default: ;
      endcase
   end

   // ---- RAMs: one write port, one registered read port each ----
   always_ff @(posedge clock) begin
      if (tree_we) begin
         fwd_mem[tree_wa] <= fwd_wd;
         rev_mem[tree_wa] <= rev_wd;
      end
      fwd_rd_ff <= fwd_mem[tree_ra];
      rev_rd_ff <= rev_mem[tree_ra];
   end

   always_ff @(posedge clock) begin
      if (pow_we) begin
         pow_mem[pow_wa] <= pow_wd;
      end
      pow_rd_ff <= pow_mem[pow_ra];
   end

   // ---- sequencer ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         len_ff       <= LEN_W'(CAPACITY);
         clr_ff       <= '0;
         k_ff         <= '0;
         pw_ff        <= HASH_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;

         // length register, clamped to 1..CAPACITY on write
         if (csr_valid) begin
            if (csr_wdata == '0) begin
               len_ff <= LEN_W'(1);
            end else if (csr_wdata > LEN_W'(CAPACITY)) begin
               len_ff <= LEN_W'(CAPACITY);
            end else begin
               len_ff <= csr_wdata;
            end
         end

         case (state_ff)
            S_CLR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == '1) begin
                  k_ff     <= CAP_BITS'(1);
                  pw_ff    <= HASH_W'(1);
                  state_ff <= S_PW_MUL;
               end
            end
            S_PW_MUL: state_ff <= S_PW_WAIT;
            S_PW_WAIT: begin
               if (mm_done) begin
                  pw_ff <= mm_prod;
                  k_ff  <= k_ff + 1'b1;
                  state_ff <= (k_ff == '1) ? S_IDLE : S_PW_MUL;
               end
            end
            S_IDLE: begin
               if (start) begin
                  pos_ff <= req_position;
                  end_ff <= req_range_end;
                  ch_ff  <= req_char_value;
                  if (req_action == ACT_SET) begin
                     if (LEN_W'(req_position) < len_ff) begin
                        state_ff <= S_SET_P1;
                     end
                  end else if (req_position > req_range_end ||
                               LEN_W'(req_range_end) >= len_ff) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_pal_ff   <= 1'b0;
                     rsp_fwd_ff   <= '0;
                     rsp_rev_ff   <= '0;
                     rsp_err_ff   <= 1'b1;
                  end else begin
                     fv_ff    <= '0;
                     rv_ff    <= '0;
                     l_ff     <= IDX_BITS'(CAPACITY) + IDX_BITS'(req_position);
                     r_ff     <= IDX_BITS'(CAPACITY) + IDX_BITS'(req_range_end) + 1'b1;
                     state_ff <= S_Q_L;
                  end
               end
            end
            // set: forward weight, reverse weight, leaf, then climb
            S_SET_P1: state_ff <= S_SET_M1;
            S_SET_M1: state_ff <= S_SET_W1;
            S_SET_W1: begin
               if (mm_done) begin
                  fv_ff    <= mm_prod;
                  state_ff <= S_SET_P2;
               end
            end
            S_SET_P2: state_ff <= S_SET_M2;
            S_SET_M2: state_ff <= S_SET_W2;
            S_SET_W2: begin
               if (mm_done) begin
                  rv_ff    <= mm_prod;
                  node_ff  <= NODE_BITS'(CAPACITY) + NODE_BITS'(pos_ff);
                  state_ff <= S_UP_RD;
               end
            end
            S_UP_RD: state_ff <= S_UP_WR;
            S_UP_WR: begin
               // parent = own value + sibling, written this cycle
               fv_ff   <= up_fwd;
               rv_ff   <= up_rev;
               node_ff <= parent;
               state_ff <= (parent == NODE_BITS'(1)) ? S_IDLE : S_UP_RD;
            end
            // query: bottom-up range walk, left edge then right edge
            S_Q_L: begin
               if (l_ff >= r_ff) begin
                  state_ff <= S_AL_RD;
               end else if (l_ff[0]) begin
                  state_ff <= S_Q_LD;
               end else begin
                  state_ff <= S_Q_R;
               end
            end
            S_Q_LD: begin
               fv_ff    <= up_fwd;
               rv_ff    <= up_rev;
               l_ff     <= l_ff + 1'b1;
               state_ff <= S_Q_R;
            end
            S_Q_R: begin
               if (r_ff[0]) begin
                  r_ff     <= r_ff - 1'b1;
                  state_ff <= S_Q_RD;
               end else begin
                  l_ff     <= l_ff >> 1;
                  r_ff     <= r_ff >> 1;
                  state_ff <= S_Q_L;
               end
            end
            S_Q_RD: begin
               fv_ff    <= up_fwd;
               rv_ff    <= up_rev;
               l_ff     <= l_ff >> 1;
               r_ff     <= r_ff >> 1;
               state_ff <= S_Q_L;
            end
            // align the lighter sum by 199^|pos - mirror|
            S_AL_RD: begin
               al_fwd_ff <= (pos_ff < mirror);
               state_ff  <= (pos_ff == mirror) ? S_OUT : S_AL_M;
            end
            S_AL_M: state_ff <= S_AL_W;
            S_AL_W: begin
               if (mm_done) begin
                  if (al_fwd_ff) begin
                     fv_ff <= mm_prod;
                  end else begin
                     rv_ff <= mm_prod;
                  end
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               rsp_valid_ff <= 1'b1;
               rsp_pal_ff   <= (fv_ff == rv_ff);
               rsp_fwd_ff   <= fv_ff;
               rsp_rev_ff   <= rv_ff;
               rsp_err_ff   <= 1'b0;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_is_palindrome = rsp_pal_ff;
   assign rsp_forward_hash  = rsp_fwd_ff;
   assign rsp_reverse_hash  = rsp_rev_ff;
   assign rsp_range_error   = rsp_err_ff;

endmodule
`default_nettype wire
